// ----- sv/pbrd_pkg.sv -----
// Shared types, codes and constants of the PackBits row decoder.
`default_nettype none
package pbrd_pkg;

    localparam int unsigned MAX_ROW_BYTES_DEF = 4096;
    localparam int unsigned ROW_BYTES_W       = 13;
    localparam int unsigned SRC_W             = 24;
    localparam int unsigned CFG_IDX_W         = 2;
    localparam int unsigned CFG_DATA_W        = 24;
    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 13'd40;
    localparam logic [7:0] HDR_NOP = 8'h80;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BUDGET = 2'd1;

    // fault codes
    localparam logic [2:0] FLT_NONE       = 3'd0;
    localparam logic [2:0] FLT_NO_SOURCE  = 3'd1;
    localparam logic [2:0] FLT_LIT_SOURCE = 3'd2;
    localparam logic [2:0] FLT_LIT_ROW    = 3'd3;
    localparam logic [2:0] FLT_REP_SOURCE = 3'd4;
    localparam logic [2:0] FLT_REP_ROW    = 3'd5;

    // header kinds
    localparam logic [1:0] KIND_NOP = 2'd0;
    localparam logic [1:0] KIND_LIT = 2'd1;
    localparam logic [1:0] KIND_REP = 2'd2;

    // datapath operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_HDR  = 3'd1;
    localparam logic [2:0] OP_LIT  = 3'd2;
    localparam logic [2:0] OP_REPD = 3'd3;
    localparam logic [2:0] OP_EMIT = 3'd4;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       discard;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic [1:0] byte_count;
        logic       row_end;
        logic       run_end;
        logic [2:0] fault;
    } out_item_t;

    typedef struct packed {
        logic [2:0] op;
    } cmd_t;

    typedef struct packed {
        logic [2:0] hdr_fault;
        logic [1:0] hdr_kind;
        logic       lit_last;
        logic       emit_last;
        logic       skip;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- sv/pbrd_ctrl.sv -----
// Controller state machine of the PackBits row decoder.
`default_nettype none
module pbrd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            restart,
    output logic                 in_ready,
    input  wire pbrd_pkg::status_t sts,
    output pbrd_pkg::cmd_t       cmd
);
    import pbrd_pkg::*;

    localparam logic [2:0] S_HDR  = 3'd0;
    localparam logic [2:0] S_LIT  = 3'd1;
    localparam logic [2:0] S_REPD = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_HALT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign in_ready = sts.out_free && (state_reg != S_EMIT);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.op = OP_NONE;
        if (accept)
        begin
            if (restart || state_reg == S_HDR)
                cmd.op = OP_HDR;
            else if (state_reg == S_LIT)
                cmd.op = OP_LIT;
            else if (state_reg == S_REPD)
                cmd.op = OP_REPD;
        end
        else if (state_reg == S_EMIT && sts.out_free)
        begin
            cmd.op = OP_EMIT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (cmd.op)
            OP_HDR:
            begin
                if (sts.hdr_fault != FLT_NONE)
                    state_next = S_HALT;
                else if (sts.hdr_kind == KIND_LIT)
                    state_next = S_LIT;
                else if (sts.hdr_kind == KIND_REP)
                    state_next = S_REPD;
                else
                    state_next = S_HDR;
            end
            OP_LIT:  state_next = sts.lit_last ? S_HDR : S_LIT;
            OP_REPD: state_next = sts.skip ? S_HDR : S_EMIT;
            OP_EMIT: state_next = sts.emit_last ? S_HDR : S_EMIT;
            default: state_next = state_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_HDR;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ----- sv/pbrd_datapath.sv -----
// Datapath of the PackBits row decoder: budgets, run counter, output register.
`default_nettype none
module pbrd_datapath #(
    parameter int unsigned MAX_ROW_BYTES = pbrd_pkg::MAX_ROW_BYTES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire pbrd_pkg::in_item_t                 in_item,
    input  wire logic                               cfg_we,
    input  wire logic [pbrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pbrd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire pbrd_pkg::cmd_t                     cmd,
    output pbrd_pkg::status_t                       sts,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output pbrd_pkg::out_item_t                     out_item
);
    import pbrd_pkg::*;

    localparam int unsigned RL_W = $clog2(MAX_ROW_BYTES + 1);

    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [SRC_W-1:0]       source_budget_reg;
    logic [SRC_W-1:0]       source_left_reg, source_left_next;
    logic [RL_W-1:0]        row_left_reg, row_left_next;
    logic [7:0]             run_left_reg, run_left_next;
    logic                   skip_reg, skip_next;
    logic [7:0]             rep_byte_reg;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_item_reg, out_item_next;

    // header evaluation
    logic [SRC_W-1:0]       src_eff, src_dec, src_need;
    logic [RL_W-1:0]        row_eff0, row_eff, row_clamp;
    logic [ROW_BYTES_W-1:0] rb_min1;
    logic                   row_start, skip_eff, is_lit, is_nop;
    logic [7:0]             lit_n, rep_n, run_n, byte_in;
    logic [2:0]             fault;
    logic [1:0]             emit_cnt;

    assign byte_in   = in_item.source_byte;
    assign src_eff   = in_item.restart ? source_budget_reg : source_left_reg;
    assign row_eff0  = in_item.restart ? '0 : row_left_reg;
    assign row_start = (row_eff0 == '0);
    assign rb_min1   = (row_bytes_reg == '0) ? ROW_BYTES_W'(1) : row_bytes_reg;
    assign row_clamp = (32'(rb_min1) > MAX_ROW_BYTES) ? RL_W'(MAX_ROW_BYTES)
                                                      : RL_W'(rb_min1);
    assign row_eff   = row_start ? row_clamp : row_eff0;
    assign skip_eff  = row_start ? in_item.discard
                                 : (in_item.restart ? 1'b0 : skip_reg);
    assign src_dec   = src_eff - SRC_W'(1);
    assign is_lit    = !byte_in[7];
    assign is_nop    = (byte_in == HDR_NOP);
    assign lit_n     = {1'b0, byte_in[6:0]} + 8'd1;
    assign rep_n     = 8'd1 - byte_in;          // 257 - b, 2..128
    assign run_n     = is_lit ? lit_n : rep_n;
    assign src_need  = is_lit ? SRC_W'(lit_n) : SRC_W'(1);

    always_comb
    begin
        fault = FLT_NONE;
        if (src_eff == '0)
            fault = FLT_NO_SOURCE;
        else if (!is_nop)
        begin
            if (src_dec < src_need)
                fault = is_lit ? FLT_LIT_SOURCE : FLT_REP_SOURCE;
            else if (32'(row_eff) < 32'(run_n))
                fault = is_lit ? FLT_LIT_ROW : FLT_REP_ROW;
        end
    end

    assign emit_cnt = (run_left_reg >= 8'd2) ? 2'd2 : 2'd1;

    assign sts.hdr_fault = fault;
    assign sts.hdr_kind  = is_nop ? KIND_NOP : (is_lit ? KIND_LIT : KIND_REP);
    assign sts.lit_last  = (run_left_reg == 8'd1);
    assign sts.emit_last = (run_left_reg <= 8'd2);
    assign sts.skip      = skip_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        source_left_next = source_left_reg;
        row_left_next    = row_left_reg;
        run_left_next    = run_left_reg;
        skip_next        = skip_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_item_next    = out_item_reg;
        case (cmd.op)
            OP_HDR:
            begin
                // whole run charged at the header; state after a fault is don't-care
                source_left_next = is_nop ? src_dec : src_dec - src_need;
                row_left_next    = is_nop ? row_eff : row_eff - RL_W'(run_n);
                run_left_next    = run_n;
                skip_next        = skip_eff;
                if (fault != FLT_NONE)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{out_first: 8'd0, out_second: 8'd0,
                                       byte_count: 2'd0, row_end: 1'b0,
                                       run_end: 1'b1, fault: fault};
                end
            end
            OP_LIT:
            begin
                run_left_next = run_left_reg - 8'd1;
                if (!skip_reg)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{out_first: byte_in, out_second: 8'd0,
                                       byte_count: 2'd1,
                                       row_end: sts.lit_last && (row_left_reg == '0),
                                       run_end: 1'b1, fault: FLT_NONE};
                end
            end
            OP_EMIT:
            begin
                run_left_next  = run_left_reg - {6'd0, emit_cnt};
                out_valid_next = 1'b1;
                out_item_next  = '{out_first: rep_byte_reg,
                                   out_second: (emit_cnt == 2'd2) ? rep_byte_reg : 8'd0,
                                   byte_count: emit_cnt,
                                   row_end: sts.emit_last && (row_left_reg == '0),
                                   run_end: sts.emit_last, fault: FLT_NONE};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg     <= ROW_BYTES_RST;
            source_budget_reg <= '0;
            source_left_reg   <= '0;
            row_left_reg      <= '0;
            run_left_reg      <= '0;
            skip_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_ROW_BYTES)
                row_bytes_reg <= cfg_wdata[ROW_BYTES_W-1:0];
            if (cfg_we && cfg_index == CFG_SOURCE_BUDGET)
                source_budget_reg <= cfg_wdata[SRC_W-1:0];
            source_left_reg <= source_left_next;
            row_left_reg    <= row_left_next;
            run_left_reg    <= run_left_next;
            skip_reg        <= skip_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (cmd.op == OP_REPD)
            rep_byte_reg <= byte_in;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

// ----- sv/packbits_row_decoder.sv -----
// Top level of the PackBits row decoder: controller plus datapath.
// A literal data item or a faulting header gives its registered result in the cycle after it
// is accepted; a repeat data item moves the controller to the emit state, which sends the run.
// Throughput: one item per cycle while the result slot is free; a result item stalled at
// the output holds the input, as does a repeat data item, unless skipped, until its run is sent.
// Reset: rst_n is asynchronous, active low; clears FSM, budgets, output valid, row_bytes 40.
`default_nettype none
module packbits_row_decoder #(
    parameter int unsigned MAX_ROW_BYTES = pbrd_pkg::MAX_ROW_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input item channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire pbrd_pkg::in_item_t              in_item,
    // result item channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output pbrd_pkg::out_item_t                  out_item,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [pbrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pbrd_pkg::*;

    // controller decides what the datapath does with each item;
    // datapath reports header checks, run counter position and output slot
    cmd_t    cmd;
    status_t sts;

    pbrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .restart  (in_item.restart),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // budgets charged at the header, so data items only count down the run
    pbrd_datapath #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

// ----- sv/pbrd_checker.sv -----
// Port-level assertions for the PackBits row decoder, bound to the top level.
`default_nettype none
module pbrd_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire pbrd_pkg::out_item_t out_item
);
    import pbrd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item dropped or changed while stalled");

    a_fault_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.fault != FLT_NONE |->
            out_item.byte_count == 2'd0 && out_item.run_end && !out_item.row_end)
        else $error("malformed fault item");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.fault == FLT_NONE |->
            out_item.byte_count == 2'd1 || out_item.byte_count == 2'd2)
        else $error("data item with bad byte count");

    a_row_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.row_end |-> out_item.run_end)
        else $error("row end inside a run");

endmodule

bind packbits_row_decoder pbrd_checker u_pbrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
`default_nettype wire
